// ----- rtl/tcp_segment_receive_control_assert.svh -----
// assertion macros for the tcp receive control block
`ifndef TCP_SEGMENT_RECEIVE_CONTROL_ASSERT_SVH
`define TCP_SEGMENT_RECEIVE_CONTROL_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define TSRC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication outside reset
`define TSRC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/tsrc_pkg.sv -----
// shared types and constants of the tcp receive control block
package tsrc_pkg;

  localparam int unsigned CwndCapDefault = 131072;
  localparam int unsigned DupAckLimitDefault = 3;
  localparam logic [15:0] MssReset = 16'd1400;
  localparam int unsigned CwW = 23;

  localparam logic [4:0] FlagFin = 5'h01;
  localparam logic [4:0] FlagSyn = 5'h02;
  localparam logic [4:0] FlagRst = 5'h04;
  localparam logic [4:0] FlagAck = 5'h10;

  localparam logic [1:0] CfgOpenMode = 2'd0;
  localparam logic [1:0] CfgInitialSeq = 2'd1;
  localparam logic [1:0] CfgMaxSegment = 2'd2;

  localparam logic [2:0] PhClosed = 3'd0;
  localparam logic [2:0] PhListen = 3'd1;
  localparam logic [2:0] PhSynSent = 3'd2;
  localparam logic [2:0] PhSynRcvd = 3'd3;
  localparam logic [2:0] PhEst = 3'd4;

  localparam logic [2:0] KindNone = 3'd0;
  localparam logic [2:0] KindAck = 3'd1;
  localparam logic [2:0] KindSynAck = 3'd2;
  localparam logic [2:0] KindRst = 3'd3;
  localparam logic [2:0] KindRstAck = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input beat and run the segment update
    logic div_start; // start mss*mss/cwnd
    logic div_step;  // one quotient bit
    logic div_done;  // apply avoidance growth
    logic pop;       // first reply of two taken
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic two_replies;
  } dp_sts_t;

endpackage

// ----- rtl/tcp_segment_receive_control.sv -----
// the input beat is loaded, the segment checked and its first result shown;
// when needed, the avoidance division (32-step restoring divider, one
// quotient bit a cycle) runs between check and result; one segment at a time:
// the next beat waits until the last of one or two result beats is accepted
// reset: listen phase, initial_seq 0, max_segment 1400, window state from it
// a configuration write (index 0 to 2) restarts the connection from the registers
module tcp_segment_receive_control #(
  parameter int unsigned CwndCap = tsrc_pkg::CwndCapDefault,
  parameter int unsigned DupAckLimit = tsrc_pkg::DupAckLimitDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  flags_i,
  input  logic [31:0] seq_number_i,
  input  logic [31:0] ack_number_i,
  input  logic [15:0] window_i,
  input  logic [15:0] payload_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  reply_kind_o,
  output logic [31:0] reply_seq_o,
  output logic [31:0] reply_ack_o,
  output logic [2:0]  conn_state_o,
  output logic [22:0] cong_window_o,
  output logic [22:0] slow_start_limit_o,
  output logic [15:0] peer_window_now_o,
  output logic        fast_retransmit_o,
  output logic        peer_closed_o,
  output logic        was_reset_o,
  output logic        last_o
);
  import tsrc_pkg::*;
  `include "tcp_segment_receive_control_assert.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tsrc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .last_o, .cmd_o(cmd), .sts_i(sts)
  );

  tsrc_datapath #(.CwndCap(CwndCap), .DupAckLimit(DupAckLimit)) u_dp (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .flags_i, .seq_number_i, .ack_number_i, .window_i,
    .payload_length_i, .cmd_i(cmd), .sts_o(sts), .reply_kind_o, .reply_seq_o,
    .reply_ack_o, .conn_state_o, .cong_window_o, .slow_start_limit_o,
    .peer_window_now_o, .fast_retransmit_o, .peer_closed_o, .was_reset_o
  );

  `TSRC_ASSERT_IMP(a_no_in_while_out, out_valid_o, !in_ready_o)
  `TSRC_ASSERT_NXT(a_in_leads_away, in_valid_i && in_ready_o, !in_ready_o && !out_valid_o)
  `TSRC_ASSERT_NXT(a_two_then_last, out_valid_o && out_ready_i && !last_o, out_valid_o && last_o)
endmodule

// ----- rtl/tsrc_datapath.sv -----
// segment registers, connection state and serial divider
module tsrc_datapath #(
  parameter int unsigned CwndCap = tsrc_pkg::CwndCapDefault,
  parameter int unsigned DupAckLimit = tsrc_pkg::DupAckLimitDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [4:0]           flags_i,
  input  logic [31:0]          seq_number_i,
  input  logic [31:0]          ack_number_i,
  input  logic [15:0]          window_i,
  input  logic [15:0]          payload_length_i,
  input  tsrc_pkg::dp_cmd_t    cmd_i,
  output tsrc_pkg::dp_sts_t    sts_o,
  output logic [2:0]           reply_kind_o,
  output logic [31:0]          reply_seq_o,
  output logic [31:0]          reply_ack_o,
  output logic [2:0]           conn_state_o,
  output logic [22:0]          cong_window_o,
  output logic [22:0]          slow_start_limit_o,
  output logic [15:0]          peer_window_now_o,
  output logic                 fast_retransmit_o,
  output logic                 peer_closed_o,
  output logic                 was_reset_o
);
  import tsrc_pkg::*;

  logic        open_q;
  logic [31:0] iss_q;
  logic [15:0] mss_q;
  logic [2:0]  ph_q, ph_d;
  logic [31:0] snd_nxt_q, snd_nxt_d, snd_una_q, snd_una_d, rcv_q, rcv_d;
  logic [15:0] pwin_q, pwin_d;
  logic [22:0] cwnd_q, cwnd_d, ssth_q, ssth_d;
  logic [2:0]  dup_q, dup_d;
  logic        fin_q, fin_d, rst_seen_q, rst_seen_d, fast_d, fast_q;
  logic [2:0]  k0_d, k1_d, k0_q, k1_q;
  logic [31:0] s0_d, s1_d, a0_d, a1_d, s0_q, s1_q, a0_q, a1_q;
  logic        two_d, two_q, div_d, div_q;

  // restoring divider: 32-bit dividend mss*mss, 23-bit divisor
  logic [31:0] dvd_q;
  logic [31:0] quo_q;
  logic [23:0] rem_q;
  logic [5:0]  cnt_q;
  logic [23:0] rem_sh;
  logic [24:0] rem_try;
  logic [31:0] inc;
  logic [33:0] grown;
  logic [31:0] sq_prod;

  assign sq_prod = 32'(mss_q) * 32'(mss_q);
  assign rem_sh  = {rem_q[22:0], dvd_q[31]};
  assign rem_try = {1'b0, rem_sh} - {2'b0, cwnd_q};
  assign inc = (quo_q == 32'd0) ? 32'd1 : quo_q;
  assign grown = 34'(cwnd_q) + 34'(inc);

  always_comb begin
    logic [4:0]  fl;
    logic [31:0] used, acked;
    logic [24:0] c;
    logic [22:0] half, fl2, sst;
    logic [31:0] dsum;
    logic        n0;
    fl = flags_i;
    ph_d = ph_q; snd_nxt_d = snd_nxt_q; snd_una_d = snd_una_q; rcv_d = rcv_q;
    pwin_d = pwin_q; cwnd_d = cwnd_q; ssth_d = ssth_q; dup_d = dup_q;
    fin_d = fin_q; rst_seen_d = rst_seen_q; fast_d = 1'b0;
    k0_d = KindNone; k1_d = KindNone; s0_d = '0; s1_d = '0; a0_d = '0; a1_d = '0;
    n0 = 1'b0; two_d = 1'b0; div_d = 1'b0;
    used = '0; acked = '0; c = '0; half = '0; fl2 = '0; sst = '0; dsum = '0;
    if (ph_q == PhListen && (fl & FlagSyn) != 0 && (fl & FlagAck) == 0) begin
      ph_d = PhSynRcvd; rcv_d = seq_number_i + 32'd1; pwin_d = window_i;
      cwnd_d = CwW'(mss_q); ssth_d = CwW'({mss_q, 6'd0});
      snd_nxt_d = iss_q; snd_una_d = iss_q; dup_d = '0; fin_d = 1'b0;
      rst_seen_d = 1'b0;
      k0_d = KindSynAck; s0_d = iss_q; a0_d = seq_number_i + 32'd1;
    end else if (ph_q == PhListen || ph_q == PhClosed || ph_q > PhEst) begin
      if ((fl & FlagRst) == 0) begin
        if ((fl & FlagAck) != 0) begin
          k0_d = KindRst; s0_d = ack_number_i;
        end else begin
          used = 32'(payload_length_i) + (((fl & (FlagSyn | FlagFin)) != 0) ? 32'd1 : 32'd0);
          k0_d = KindRstAck; a0_d = seq_number_i + used;
        end
      end
    end else if ((fl & FlagRst) != 0) begin
      rst_seen_d = 1'b1; ph_d = PhClosed;
    end else if (ph_q == PhSynRcvd) begin
      if ((fl & FlagSyn) != 0 && (fl & FlagAck) == 0) begin
        k0_d = KindSynAck; s0_d = snd_una_q; a0_d = rcv_q;
      end else if ((fl & FlagAck) != 0 && ack_number_i == snd_una_q + 32'd1) begin
        snd_una_d = ack_number_i; snd_nxt_d = ack_number_i; pwin_d = window_i;
        ph_d = PhEst;
        if (payload_length_i != 0 && seq_number_i == rcv_q) begin
          rcv_d = rcv_q + 32'(payload_length_i);
          k0_d = KindAck; s0_d = ack_number_i; a0_d = rcv_d;
        end
      end
    end else if (ph_q == PhSynSent) begin
      if ((fl & (FlagSyn | FlagAck)) == (FlagSyn | FlagAck)) begin
        rcv_d = seq_number_i + 32'd1; snd_una_d = ack_number_i;
        snd_nxt_d = ack_number_i; pwin_d = window_i; ph_d = PhEst;
        k0_d = KindAck; s0_d = ack_number_i; a0_d = rcv_d;
      end
    end else begin
      pwin_d = window_i;
      if ((fl & FlagAck) != 0) begin
        dsum = ack_number_i - snd_una_q;
        if (dsum != 0 && !dsum[31]) begin
          acked = dsum; snd_una_d = ack_number_i; dup_d = '0;
          if (cwnd_q < ssth_q) begin
            c = 25'(cwnd_q) + ((acked < 32'(mss_q)) ? 25'(acked) : 25'(mss_q));
            if (c > 25'(CwndCap)) c = 25'(CwndCap);
            cwnd_d = c[22:0];
          end else if (cwnd_q == '0) begin
            cwnd_d = CwW'(CwndCap);
          end else begin
            div_d = 1'b1;
          end
        end else if (ack_number_i == snd_una_q && payload_length_i == 0 &&
                     (fl & FlagFin) == 0) begin
          if (dup_q != 3'd7) begin
            dup_d = dup_q + 3'd1;
            if (dup_d == 3'(DupAckLimit)) begin
              half = cwnd_q >> 1;
              fl2 = CwW'({mss_q, 1'b0});
              sst = (half > fl2) ? half : fl2;
              ssth_d = sst;
              cwnd_d = CwW'(32'(sst) + 32'(DupAckLimit) * 32'(mss_q));
              fast_d = 1'b1;
            end
          end
        end
      end
      if (payload_length_i != 0) begin
        if (seq_number_i == rcv_q) rcv_d = rcv_q + 32'(payload_length_i);
        k0_d = KindAck; s0_d = snd_nxt_q; a0_d = rcv_d; n0 = 1'b1;
      end
      if ((fl & FlagFin) != 0) begin
        fin_d = 1'b1;
        if (n0) begin
          two_d = 1'b1; k1_d = KindAck; s1_d = snd_nxt_q; a1_d = rcv_d + 32'd1;
        end else begin
          k0_d = KindAck; s0_d = snd_nxt_q; a0_d = rcv_d + 32'd1;
        end
        rcv_d = rcv_d + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0; iss_q <= '0; mss_q <= MssReset;
      ph_q <= PhListen; snd_nxt_q <= '0; snd_una_q <= '0; rcv_q <= '0;
      pwin_q <= MssReset; cwnd_q <= CwW'(MssReset); ssth_q <= CwW'({MssReset, 6'd0});
      dup_q <= '0; fin_q <= 1'b0; rst_seen_q <= 1'b0; fast_q <= 1'b0;
      two_q <= 1'b0; div_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_i && cfg_index_i <= CfgMaxSegment) begin
      logic        om;
      logic [31:0] is;
      logic [15:0] ms;
      om = open_q; is = iss_q; ms = mss_q;
      case (cfg_index_i)
        CfgOpenMode:   om = cfg_data_i[0];
        CfgInitialSeq: is = cfg_data_i;
        CfgMaxSegment: ms = cfg_data_i[15:0];
        default:       om = open_q;
      endcase
      open_q <= om; iss_q <= is; mss_q <= ms;
      ph_q <= om ? PhSynSent : PhListen; snd_nxt_q <= is; snd_una_q <= is;
      rcv_q <= '0; pwin_q <= ms; cwnd_q <= CwW'(ms); ssth_q <= CwW'({ms, 6'd0});
      dup_q <= '0; fin_q <= 1'b0; rst_seen_q <= 1'b0;
    end else if (cmd_i.load) begin
      ph_q <= ph_d; snd_nxt_q <= snd_nxt_d; snd_una_q <= snd_una_d; rcv_q <= rcv_d;
      pwin_q <= pwin_d; cwnd_q <= cwnd_d; ssth_q <= ssth_d; dup_q <= dup_d;
      fin_q <= fin_d; rst_seen_q <= rst_seen_d; fast_q <= fast_d;
      two_q <= two_d; div_q <= div_d;
    end else if (cmd_i.div_done) begin
      cwnd_q <= (grown > 34'(CwndCap)) ? CwW'(CwndCap) : grown[22:0];
    end else if (cmd_i.pop) begin
      two_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      k0_q <= k0_d; k1_q <= k1_d; s0_q <= s0_d; s1_q <= s1_d; a0_q <= a0_d; a1_q <= a1_d;
    end else if (cmd_i.pop) begin
      k0_q <= k1_q; s0_q <= s1_q; a0_q <= a1_q;
    end
    if (cmd_i.div_start) begin
      dvd_q <= sq_prod; quo_q <= '0; rem_q <= '0; cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      cnt_q <= cnt_q + 6'd1;
      if (!rem_try[24]) begin
        rem_q <= rem_try[23:0]; quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh; quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign sts_o.need_div    = div_q;
  assign sts_o.div_last    = (cnt_q == 6'd31);
  assign sts_o.two_replies = two_q;

  assign reply_kind_o       = k0_q;
  assign reply_seq_o        = s0_q;
  assign reply_ack_o        = a0_q;
  assign conn_state_o       = ph_q;
  assign cong_window_o      = cwnd_q;
  assign slow_start_limit_o = ssth_q;
  assign peer_window_now_o  = pwin_q;
  assign fast_retransmit_o  = fast_q;
  assign peer_closed_o      = fin_q;
  assign was_reset_o        = rst_seen_q;
endmodule

// ----- rtl/tsrc_ctrl.sv -----
// sequencer for segment update, division and reply delivery
module tsrc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              last_o,
  output tsrc_pkg::dp_cmd_t cmd_o,
  input  tsrc_pkg::dp_sts_t sts_i
);
  import tsrc_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StCheck, StDivInit, StDiv, StApply, StOut
  } state_e;

  state_e state_q;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign last_o      = !sts_i.two_replies;

  always_comb begin
    cmd_o = '0;
    cmd_o.load      = (state_q == StIdle) && in_valid_i;
    cmd_o.div_start = (state_q == StDivInit);
    cmd_o.div_step  = (state_q == StDiv);
    cmd_o.div_done  = (state_q == StApply);
    cmd_o.pop       = (state_q == StOut) && out_ready_i && sts_i.two_replies;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle:    if (in_valid_i) state_q <= StCheck;
        StCheck:   state_q <= sts_i.need_div ? StDivInit : StOut;
        StDivInit: state_q <= StDiv;
        StDiv:     if (sts_i.div_last) state_q <= StApply;
        StApply:   state_q <= StOut;
        StOut:     if (out_ready_i && !sts_i.two_replies) state_q <= StIdle;
        default:   state_q <= StIdle;
      endcase
    end
  end
endmodule

// ----- dv/tcp_segment_receive_control_tb.sv -----
// testbench for the tcp segment receive control block
module tcp_segment_receive_control_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsrc_pkg::*;

  localparam int unsigned CwndCap = CwndCapDefault;
  localparam int unsigned DupLimit = DupAckLimitDefault;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [4:0]  flags_i = '0;
  logic [31:0] seq_number_i = '0;
  logic [31:0] ack_number_i = '0;
  logic [15:0] window_i = '0;
  logic [15:0] payload_length_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  reply_kind_o;
  logic [31:0] reply_seq_o;
  logic [31:0] reply_ack_o;
  logic [2:0]  conn_state_o;
  logic [22:0] cong_window_o;
  logic [22:0] slow_start_limit_o;
  logic [15:0] peer_window_now_o;
  logic        fast_retransmit_o;
  logic        peer_closed_o;
  logic        was_reset_o;
  logic        last_o;

  tcp_segment_receive_control uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] rseq;
    logic [31:0] rack;
    logic [2:0]  state;
    logic [22:0] cwnd;
    logic [22:0] ssthresh;
    logic [15:0] pwin;
    logic        fast;
    logic        fin;
    logic        rst;
    logic        last;
  } reply_t;

  reply_t pending_replies[$];
  int unsigned errors = 0;
  int unsigned segs_sent = 0;
  int unsigned replies_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // shadow of the connection
  logic        m_open;
  logic [31:0] m_iss;
  logic [15:0] m_mss;
  logic [2:0]  m_phase;
  logic [31:0] m_snd_nxt, m_snd_una, m_rcv_nxt;
  logic [15:0] m_pwin;
  logic [22:0] m_cwnd, m_ssth;
  logic [2:0]  m_dups;
  logic        m_fin, m_rst;

  function automatic void conn_restart();
    m_phase = m_open ? PhSynSent : PhListen;
    m_snd_nxt = m_iss;
    m_snd_una = m_iss;
    m_rcv_nxt = '0;
    m_pwin = m_mss;
    m_cwnd = 23'(m_mss);
    m_ssth = 23'(64 * int'(m_mss));
    m_dups = '0;
    m_fin = 1'b0;
    m_rst = 1'b0;
  endfunction

  function automatic void predict_segment(logic [4:0] fl, logic [31:0] sq, logic [31:0] ak,
                                          logic [15:0] win, logic [15:0] plen);
    logic [2:0]  kinds[2];
    logic [31:0] seqs[2], acks[2];
    int n;
    logic fast;
    logic [31:0] d, acked, half, floor2;
    longint c, inc;
    reply_t r;
    n = 0;
    fast = 1'b0;
    if (m_phase == PhListen && fl[1] && !fl[4]) begin
      m_phase = PhSynRcvd;
      m_rcv_nxt = sq + 1;
      m_pwin = win;
      m_cwnd = 23'(m_mss);
      m_ssth = 23'(64 * int'(m_mss));
      m_snd_nxt = m_iss;
      m_snd_una = m_iss;
      m_dups = '0;
      m_fin = 1'b0;
      m_rst = 1'b0;
      kinds[n] = KindSynAck; seqs[n] = m_snd_nxt; acks[n] = m_rcv_nxt; n++;
    end else if (m_phase == PhListen || m_phase == PhClosed || m_phase > PhEst) begin
      if (!fl[2]) begin
        if (fl[4]) begin
          kinds[n] = KindRst; seqs[n] = ak; acks[n] = '0; n++;
        end else begin
          kinds[n] = KindRstAck; seqs[n] = '0;
          acks[n] = sq + 32'(plen) + ((fl[1] || fl[0]) ? 32'd1 : 32'd0); n++;
        end
      end
    end else if (fl[2]) begin
      m_rst = 1'b1;
      m_phase = PhClosed;
    end else if (m_phase == PhSynRcvd) begin
      if (fl[1] && !fl[4]) begin
        kinds[n] = KindSynAck; seqs[n] = m_snd_una; acks[n] = m_rcv_nxt; n++;
      end else if (fl[4] && ak == m_snd_una + 1) begin
        m_snd_una = ak;
        m_snd_nxt = ak;
        m_pwin = win;
        m_phase = PhEst;
        if (plen > 0 && sq == m_rcv_nxt) begin
          m_rcv_nxt += 32'(plen);
          kinds[n] = KindAck; seqs[n] = m_snd_nxt; acks[n] = m_rcv_nxt; n++;
        end
      end
    end else if (m_phase == PhSynSent) begin
      if (fl[1] && fl[4]) begin
        m_rcv_nxt = sq + 1;
        m_snd_una = ak;
        m_snd_nxt = ak;
        m_pwin = win;
        m_phase = PhEst;
        kinds[n] = KindAck; seqs[n] = m_snd_nxt; acks[n] = m_rcv_nxt; n++;
      end
    end else begin
      m_pwin = win;
      if (fl[4]) begin
        d = ak - m_snd_una;
        if (d != 0 && !d[31]) begin
          acked = d;
          c = longint'(m_cwnd);
          m_snd_una = ak;
          m_dups = '0;
          if (c < longint'(m_ssth)) c += (acked < 32'(m_mss)) ? longint'(acked) : longint'(m_mss);
          else if (c == 0) c = CwndCap;
          else begin
            inc = (longint'(m_mss) * longint'(m_mss)) / c;
            c += (inc < 1) ? 1 : inc;
          end
          if (c > CwndCap) c = CwndCap;
          m_cwnd = 23'(c);
        end else if (ak == m_snd_una && plen == 0 && !fl[0]) begin
          if (m_dups < 7) begin
            m_dups++;
            if (m_dups == 3'(DupLimit)) begin
              half = 32'(m_cwnd) / 2;
              floor2 = 2 * 32'(m_mss);
              m_ssth = 23'((half > floor2) ? half : floor2);
              m_cwnd = 23'(32'(m_ssth) + DupLimit * 32'(m_mss));
              fast = 1'b1;
            end
          end
        end
      end
      if (plen > 0) begin
        if (sq == m_rcv_nxt) m_rcv_nxt += 32'(plen);
        kinds[n] = KindAck; seqs[n] = m_snd_nxt; acks[n] = m_rcv_nxt; n++;
      end
      if (fl[0]) begin
        m_rcv_nxt += 1;
        m_fin = 1'b1;
        kinds[n] = KindAck; seqs[n] = m_snd_nxt; acks[n] = m_rcv_nxt; n++;
      end
    end
    if (n == 0) begin
      kinds[0] = KindNone; seqs[0] = '0; acks[0] = '0; n = 1;
    end
    for (int k = 0; k < n; k++) begin
      r.kind = kinds[k]; r.rseq = seqs[k]; r.rack = acks[k];
      r.state = m_phase; r.cwnd = m_cwnd; r.ssthresh = m_ssth; r.pwin = m_pwin;
      r.fast = fast; r.fin = m_fin; r.rst = m_rst; r.last = (k == n - 1);
      pending_replies.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // random receiver stall and result checking
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    reply_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply beat", 32'd1, 32'd0);
      end else begin
        w = pending_replies.pop_front();
        if (reply_kind_o !== w.kind)
          report_mismatch("reply_kind", 32'(reply_kind_o), 32'(w.kind));
        if (reply_seq_o !== w.rseq) report_mismatch("reply_seq", reply_seq_o, w.rseq);
        if (reply_ack_o !== w.rack) report_mismatch("reply_ack", reply_ack_o, w.rack);
        if (conn_state_o !== w.state)
          report_mismatch("conn_state", 32'(conn_state_o), 32'(w.state));
        if (cong_window_o !== w.cwnd)
          report_mismatch("cong_window", 32'(cong_window_o), 32'(w.cwnd));
        if (slow_start_limit_o !== w.ssthresh)
          report_mismatch("slow_start_limit", 32'(slow_start_limit_o), 32'(w.ssthresh));
        if (peer_window_now_o !== w.pwin)
          report_mismatch("peer_window_now", 32'(peer_window_now_o), 32'(w.pwin));
        if (fast_retransmit_o !== w.fast)
          report_mismatch("fast_retransmit", 32'(fast_retransmit_o), 32'(w.fast));
        if (peer_closed_o !== w.fin)
          report_mismatch("peer_closed", 32'(peer_closed_o), 32'(w.fin));
        if (was_reset_o !== w.rst) report_mismatch("was_reset", 32'(was_reset_o), 32'(w.rst));
        if (last_o !== w.last) report_mismatch("last", 32'(last_o), 32'(w.last));
      end
    end
  end

  task automatic push_segment(logic [4:0] fl, logic [31:0] sq, logic [31:0] ak,
                              logic [15:0] win, logic [15:0] plen);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i <= 1'b1;
    flags_i <= fl;
    seq_number_i <= sq;
    ack_number_i <= ak;
    window_i <= win;
    payload_length_i <= plen;
    do @(posedge clk_i); while (!in_ready_o);
    predict_segment(fl, sq, ak, win, plen);
    segs_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgOpenMode) m_open = val[0];
    else if (idx == CfgInitialSeq) m_iss = val;
    else if (idx == CfgMaxSegment) m_mss = val[15:0];
    if (idx <= CfgMaxSegment) conn_restart();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random flags, rarely with rst set
  function automatic logic [4:0] rand_flags();
    logic [4:0] f;
    f = 5'($urandom_range(31));
    f[2] = ($urandom_range(39) == 0);
    return f;
  endfunction

  // bring the connection to established and hammer it with realistic traffic
  task automatic run_connection(int unsigned count);
    logic [31:0] peer_seq, una;
    int unsigned i;
    peer_seq = $urandom;
    if (m_open) push_segment(FlagSyn | FlagAck, peer_seq, m_iss + 1, 16'($urandom), 16'd0);
    else begin
      push_segment(FlagSyn, peer_seq, $urandom, 16'($urandom), 16'd0);
      push_segment(FlagAck, peer_seq + 1, m_iss + 1, 16'($urandom), 16'($urandom_range(3)));
    end
    for (i = 0; i < count && m_phase == PhEst; i++) begin
      logic [4:0] fl;
      logic [15:0] plen;
      logic [31:0] ak;
      una = m_snd_una;
      fl = FlagAck;
      case ($urandom_range(9))
        0, 1, 2: ak = una + $urandom_range(3000);
        3, 4, 5: ak = una;
        6: ak = $urandom;
        default: ak = una + $urandom_range(20);
      endcase
      plen = ($urandom_range(2) == 0) ? 16'($urandom_range(2000)) : 16'd0;
      if ($urandom_range(29) == 0) fl |= FlagFin;
      if ($urandom_range(19) == 0) fl = rand_flags();
      if ($urandom_range(150) == 0) fl |= FlagRst;
      push_segment(fl, ($urandom_range(4) == 0) ? $urandom : m_rcv_nxt, ak,
                   16'($urandom), plen);
    end
  endtask

  task automatic test_directed();
    push_segment(FlagAck, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff);
    push_segment(5'h00, 32'hffff_ffff, 32'h0, 16'h0, 16'hffff);
    push_segment(FlagFin, 32'h0, 32'h0, 16'h0, 16'h0);
    push_segment(FlagRst, 32'h1234, 32'h0, 16'h0, 16'h0);
    push_segment(5'h1f, 32'h0, 32'h0, 16'h0, 16'h0);
    push_segment(FlagSyn, 32'h7fff_ffff, 32'h0, 16'hffff, 16'h0);
    push_segment(FlagSyn, 32'h7fff_ffff, 32'h0, 16'h0, 16'h0);
    push_segment(FlagAck, 32'h8000_0000, m_iss + 1, 16'h1000, 16'd10);
    push_segment(FlagAck, m_rcv_nxt + 5, m_iss + 1, 16'h0, 16'd10);
    for (int k = 0; k < 9; k++) push_segment(FlagAck, m_rcv_nxt, m_snd_una, 16'h55, 16'h0);
    push_segment(FlagAck | FlagFin, m_rcv_nxt, m_snd_una + 100, 16'h8, 16'd4);
    push_segment(FlagAck, m_rcv_nxt, m_snd_una + 32'h8000_0000, 16'h8, 16'h0);
    push_segment(FlagRst, 32'h0, 32'h0, 16'h0, 16'h0);
    push_segment(FlagAck, 32'h0, 32'hdead_beef, 16'h0, 16'h0);
  endtask

  // avoidance with zero cwnd, tiny and huge mss, active open
  task automatic test_config_extremes();
    write_reg(CfgMaxSegment, 32'h1);
    write_reg(CfgInitialSeq, 32'hffff_ffff);
    run_connection(40);
    write_reg(CfgMaxSegment, 32'hffff);
    write_reg(CfgOpenMode, 32'h1);
    push_segment(FlagAck, 32'h0, 32'h0, 16'h0, 16'h0);
    run_connection(40);
    write_reg(CfgMaxSegment, 32'h0);
    write_reg(CfgOpenMode, 32'h0);
    write_reg(CfgInitialSeq, 32'h0);
    run_connection(20);
    write_reg(2'd3, 32'h1234);
  endtask

  task automatic test_random_traffic(int unsigned total);
    while (segs_sent < total) begin
      case ($urandom_range(5))
        0: write_reg(CfgOpenMode, $urandom_range(1));
        1: write_reg(CfgInitialSeq, $urandom);
        2: write_reg(CfgMaxSegment, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 1500));
        default: ;
      endcase
      run_connection($urandom_range(20, 120));
      for (int k = $urandom_range(6); k > 0; k--)
        push_segment(rand_flags(), $urandom, $urandom, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    m_open = 1'b0;
    m_iss = '0;
    m_mss = MssReset;
    conn_restart();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_config_extremes();
    test_random_traffic(500);
    send_idle_pct = 73;
    test_random_traffic(800);
    send_idle_pct = 0;
    recv_stall_pct = 73;
    test_random_traffic(1100);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    test_random_traffic(1500);
    drain();
    $display("covered %0d segments and %0d reply beats over handshakes, congestion control",
             segs_sent, replies_seen);
    $display("and resets under four idling mixes");
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule

// ----- tcp_segment_receive_control.f -----
+incdir+rtl
rtl/tsrc_pkg.sv
rtl/tsrc_datapath.sv
rtl/tsrc_ctrl.sv
rtl/tcp_segment_receive_control.sv
dv/tcp_segment_receive_control_tb.sv
